// File: hw/rtl/fpm_pkg.sv
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared types, constants and single-precision helpers for the remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fpm_pkg;

   localparam int DOUBLING_LIMIT_DEF = 128;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
   localparam logic [7:0]  EXP_MAX     = 8'hFF;
   localparam logic [7:0]  EXP_HUGE    = 8'd180;   // bias + 53

   localparam logic [1:0] CLS_HUGE    = 2'd0;
   localparam logic [1:0] CLS_INVALID = 2'd1;
   localparam logic [1:0] CLS_REDUCE  = 2'd2;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] modulus;
      logic [1:0]  cls;
   } entry_type;

   typedef struct packed {
      logic      empty;
      entry_type head;
   } queue_status_type;

   function automatic logic is_nan(input logic [31:0] x);
      return (x[30:23] == EXP_MAX) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic is_zero(input logic [31:0] x);
      return x[30:0] == 31'd0;
   endfunction

   function automatic logic is_neg(input logic [31:0] x);
      return x[31] && !is_zero(x) && !is_nan(x);
   endfunction

   function automatic logic is_pos(input logic [31:0] x);
      return !x[31] && !is_zero(x) && !is_nan(x);
   endfunction

   function automatic logic [31:0] order_key(input logic [31:0] x);
      return x[31] ? ~x : {1'b1, x[30:0]};
   endfunction

   // a >= b, false on NaN, +0 == -0
   function automatic logic ge(input logic [31:0] a, input logic [31:0] b);
      logic r;
      if (is_nan(a) || is_nan(b)) begin
         r = 1'b0;
      end else if (is_zero(a) && is_zero(b)) begin
         r = 1'b1;
      end else begin
         r = order_key(a) >= order_key(b);
      end
      return r;
   endfunction

   // x * 0.5, round to nearest even
   function automatic logic [31:0] half(input logic [31:0] x);
      logic [31:0] r;
      logic [23:0] s;
      logic [23:0] q;
      s = {x[23], x[22:0]};
      q = {1'b0, s[23:1]} + {23'd0, s[0] & s[1]};
      if (x[30:23] == EXP_MAX) begin
         r = x;
      end else if (x[30:23] > 8'd1) begin
         r = {x[31], x[30:23] - 8'd1, x[22:0]};
      end else begin
         r = {x[31], 7'd0, q};
      end
      return r;
   endfunction

   // |m| > 2^53 or infinite
   function automatic logic is_huge(input logic [31:0] m);
      logic [7:0] e;
      e = m[30:23];
      return ((e == EXP_MAX) && (m[22:0] == 23'd0)) ||
             ((e != EXP_MAX) && ((e > EXP_HUGE) || ((e == EXP_HUGE) && (m[22:0] != 23'd0))));
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fpm_front.sv
// ----------------------------------------------------------------------------
// fpm_front
// Accepts request beats and classifies the modulus before queueing.
// ----------------------------------------------------------------------------
`default_nettype none

module fpm_front (
   input  wire logic           start,
   input  wire logic [31:0]    req_value_bits,
   input  wire logic [31:0]    req_modulus_bits,
   input  wire logic           queue_full,
   output fpm_pkg::entry_type  push_entry,
   output logic                push,
   output logic                busy
);

   logic [1:0] cls;

   always_comb begin
      if (fpm_pkg::is_huge(req_modulus_bits)) begin
         cls = fpm_pkg::CLS_HUGE;
      end else if (!fpm_pkg::is_pos(req_modulus_bits)) begin
         cls = fpm_pkg::CLS_INVALID;
      end else begin
         cls = fpm_pkg::CLS_REDUCE;
      end
   end

   assign busy               = queue_full;
   assign push               = start && !queue_full;
   assign push_entry.value   = req_value_bits;
   assign push_entry.modulus = req_modulus_bits;
   assign push_entry.cls     = cls;

endmodule

`default_nettype wire

// File: hw/rtl/fpm_queue.sv
// ----------------------------------------------------------------------------
// fpm_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fpm_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  fpm_pkg::entry_type         push_entry,
   input  wire logic                  pop,
   output fpm_pkg::queue_status_type  status,
   output logic                       full
);

   localparam int D  = fpm_pkg::QUEUE_DEPTH;
   localparam int PW = (D > 1) ? $clog2(D) : 1;
   localparam int CW = $clog2(D + 1);

   fpm_pkg::entry_type slots_ff [D];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(D - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(D - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end

   assign status.empty = cnt_ff == '0;
   assign status.head  = slots_ff[rd_ff];
   assign full         = cnt_ff == CW'(D);

endmodule

`default_nettype wire

// File: hw/rtl/fpm_add.sv
// ----------------------------------------------------------------------------
// fpm_add
// Four-stage single-precision adder, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
`default_nettype none

module fpm_add (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic             done,
   output logic [31:0]      sum
);

   // stage 1: swap and align
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        sp1_ff, sp2_ff, sp3_ff;
   logic [31:0] spv1_ff, spv2_ff, spv3_ff;
   logic        sub1_ff, sign1_ff, zs1_ff;
   logic [7:0]  e1_ff;
   logic [26:0] ab1_ff, bb1_ff;

   logic        sp_in;
   logic [31:0] spv_in;
   logic [31:0] big, sml;
   logic [7:0]  eb, es, d;
   logic [26:0] ext_b, ext_s, shf;
   logic        sticky;

   always_comb begin
      logic a_inf, b_inf;
      a_inf = (a[30:23] == fpm_pkg::EXP_MAX) && (a[22:0] == 23'd0);
      b_inf = (b[30:23] == fpm_pkg::EXP_MAX) && (b[22:0] == 23'd0);
      sp_in  = 1'b1;
      spv_in = fpm_pkg::CANON_NAN;
      if (fpm_pkg::is_nan(a) || fpm_pkg::is_nan(b) || (a_inf && b_inf && (a[31] != b[31]))) begin
         spv_in = fpm_pkg::CANON_NAN;
      end else if (a_inf) begin
         spv_in = a;
      end else if (b_inf) begin
         spv_in = b;
      end else begin
         sp_in = 1'b0;
      end
      if (b[30:0] > a[30:0]) begin
         big = b;
         sml = a;
      end else begin
         big = a;
         sml = b;
      end
      eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d     = eb - es;
      ext_b = {big[30:23] != 8'd0, big[22:0], 3'b000};
      ext_s = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
      if (d >= 8'd27) begin
         shf    = '0;
         sticky = ext_s != '0;
      end else begin
         shf    = ext_s >> d;
         sticky = (shf << d) != ext_s;
      end
   end

   // stage 2: add
   logic [27:0] s2_ff;
   logic [7:0]  e2_ff;
   logic        sign2_ff, zs2_ff;

   // stage 3: normalize
   logic [26:0] n3_ff;
   logic [9:0]  e3_ff;
   logic        sign3_ff, zero3_ff, zs3_ff;

   logic [26:0] n_in;
   logic [9:0]  e_in;
   logic [4:0]  lz;
   logic [7:0]  sh;

   always_comb begin
      lz = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (s2_ff[i]) begin
            lz = 5'(26 - i);
         end
      end
      sh = ({3'd0, lz} < (e2_ff - 8'd1)) ? {3'd0, lz} : (e2_ff - 8'd1);
      if (s2_ff[27]) begin
         n_in = {s2_ff[27:2], s2_ff[1] | s2_ff[0]};
         e_in = {2'b00, e2_ff} + 10'd1;
      end else begin
         n_in = s2_ff[26:0] << sh;
         e_in = {2'b00, e2_ff} - {2'b00, sh};
      end
   end

   // stage 4: round and pack
   logic [31:0] r4_ff, r_in;

   always_comb begin
      logic        up;
      logic [24:0] m;
      logic [9:0]  ef;
      up = n3_ff[2] & (n3_ff[1] | n3_ff[0] | n3_ff[3]);
      m  = {1'b0, n3_ff[26:3]} + {24'd0, up};
      if (m[24]) begin
         ef = e3_ff + 10'd1;
      end else if (m[23]) begin
         ef = e3_ff;
      end else begin
         ef = 10'd0;
      end
      if (sp3_ff) begin
         r_in = spv3_ff;
      end else if (zero3_ff) begin
         r_in = {zs3_ff, 31'd0};
      end else if (ef >= 10'd255) begin
         r_in = {sign3_ff, fpm_pkg::EXP_MAX, 23'd0};
      end else begin
         r_in = {sign3_ff, ef[7:0], m[24] ? 23'd0 : m[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= go;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      sp1_ff   <= sp_in;
      spv1_ff  <= spv_in;
      sub1_ff  <= a[31] ^ b[31];
      sign1_ff <= big[31];
      zs1_ff   <= a[31] & b[31];
      e1_ff    <= eb;
      ab1_ff   <= ext_b;
      bb1_ff   <= {shf[26:1], shf[0] | sticky};

      sp2_ff   <= sp1_ff;
      spv2_ff  <= spv1_ff;
      sign2_ff <= sign1_ff;
      zs2_ff   <= zs1_ff;
      e2_ff    <= e1_ff;
      s2_ff    <= sub1_ff ? ({1'b0, ab1_ff} - {1'b0, bb1_ff})
                          : ({1'b0, ab1_ff} + {1'b0, bb1_ff});

      sp3_ff   <= sp2_ff;
      spv3_ff  <= spv2_ff;
      sign3_ff <= sign2_ff;
      zs3_ff   <= zs2_ff;
      zero3_ff <= s2_ff == '0;
      n3_ff    <= n_in;
      e3_ff    <= e_in;

      r4_ff    <= r_in;
   end

   assign done = v4_ff;
   assign sum  = r4_ff;

endmodule

`default_nettype wire

// File: hw/rtl/fpm_back.sv
// ----------------------------------------------------------------------------
// fpm_back
// Sequencer that lifts, doubles and reduces one queued item on a shared adder.
// ----------------------------------------------------------------------------
`default_nettype none

module fpm_back #(
   parameter int DOUBLING_LIMIT = fpm_pkg::DOUBLING_LIMIT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  fpm_pkg::queue_status_type  status,
   output logic                       pop,
   output logic                       rsp_strobe,
   output logic [31:0]                rsp_remainder_bits,
   output logic                       rsp_modulus_invalid
);

   localparam int NW = $clog2(DOUBLING_LIMIT + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_L_ADD = 4'd1;
   localparam logic [3:0] S_L_DBL = 4'd2;
   localparam logic [3:0] S_P_CHK = 4'd3;
   localparam logic [3:0] S_D_CMP = 4'd4;
   localparam logic [3:0] S_D_WT  = 4'd5;
   localparam logic [3:0] S_H_STP = 4'd6;
   localparam logic [3:0] S_H_CMP = 4'd7;
   localparam logic [3:0] S_S_WT  = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [31:0]   v_ff, v_in, t_ff, t_in, m_ff, m_in;
   logic [NW-1:0] n_ff, n_in;
   logic [31:0]   add_a_ff, add_a_in, add_b_ff, add_b_in;
   logic          go_ff, go_in;
   logic          str_ff, str_in;
   logic [31:0]   rem_ff, rem_in;
   logic          inv_ff, inv_in;
   logic          done;
   logic [31:0]   sum;

   fpm_add u_add (
      .clock (clock),
      .reset (reset),
      .go    (go_ff),
      .a     (add_a_ff),
      .b     (add_b_ff),
      .done  (done),
      .sum   (sum)
   );

   assign pop = (state_ff == S_IDLE) && !status.empty;

   always_comb begin
      state_in = state_ff;
      v_in     = v_ff;
      t_in     = t_ff;
      m_in     = m_ff;
      n_in     = n_ff;
      add_a_in = add_a_ff;
      add_b_in = add_b_ff;
      go_in    = 1'b0;
      str_in   = 1'b0;
      rem_in   = rem_ff;
      inv_in   = inv_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!status.empty) begin
               v_in = status.head.value;
               m_in = status.head.modulus;
               t_in = status.head.modulus;
               unique case (status.head.cls)
                  fpm_pkg::CLS_HUGE: begin
                     str_in = 1'b1;
                     rem_in = 32'd0;
                     inv_in = 1'b0;
                  end
                  fpm_pkg::CLS_INVALID: begin
                     str_in = 1'b1;
                     rem_in = status.head.value;
                     inv_in = 1'b1;
                  end
                  default: begin
                     if (fpm_pkg::is_neg(status.head.value)) begin
                        add_a_in = status.head.value;
                        add_b_in = status.head.modulus;
                        go_in    = 1'b1;
                        state_in = S_L_ADD;
                     end else begin
                        state_in = S_P_CHK;
                     end
                  end
               endcase
            end
         end
         S_L_ADD: begin
            if (done) begin
               if (fpm_pkg::is_neg(sum)) begin
                  add_a_in = t_ff;
                  add_b_in = t_ff;
                  go_in    = 1'b1;
                  state_in = S_L_DBL;
               end else begin
                  v_in     = sum;
                  t_in     = m_ff;
                  state_in = S_P_CHK;
               end
            end
         end
         S_L_DBL: begin
            if (done) begin
               t_in     = sum;
               add_a_in = v_ff;
               add_b_in = sum;
               go_in    = 1'b1;
               state_in = S_L_ADD;
            end
         end
         S_P_CHK: begin
            n_in     = '0;
            state_in = fpm_pkg::is_pos(v_ff) ? S_D_CMP : S_FIN;
         end
         S_D_CMP: begin
            if (fpm_pkg::ge(v_ff, t_ff) && (n_ff < NW'(DOUBLING_LIMIT))) begin
               add_a_in = t_ff;
               add_b_in = t_ff;
               go_in    = 1'b1;
               state_in = S_D_WT;
            end else begin
               state_in = S_H_STP;
            end
         end
         S_D_WT: begin
            if (done) begin
               t_in     = sum;
               n_in     = n_ff + 1'b1;
               state_in = S_D_CMP;
            end
         end
         S_H_STP: begin
            if (n_ff == '0) begin
               state_in = S_FIN;
            end else begin
               t_in     = fpm_pkg::half(t_ff);
               n_in     = n_ff - 1'b1;
               state_in = S_H_CMP;
            end
         end
         S_H_CMP: begin
            if (fpm_pkg::ge(v_ff, t_ff)) begin
               add_a_in = v_ff;
               add_b_in = {~t_ff[31], t_ff[30:0]};
               go_in    = 1'b1;
               state_in = S_S_WT;
            end else begin
               state_in = S_H_STP;
            end
         end
         S_S_WT: begin
            if (done) begin
               v_in     = sum;
               state_in = S_H_STP;
            end
         end
         S_FIN: begin
            str_in   = 1'b1;
            rem_in   = v_ff;
            inv_in   = 1'b0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         go_ff    <= 1'b0;
         str_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         str_ff   <= str_in;
      end
      v_ff     <= v_in;
      t_ff     <= t_in;
      m_ff     <= m_in;
      n_ff     <= n_in;
      add_a_ff <= add_a_in;
      add_b_ff <= add_b_in;
      rem_ff   <= rem_in;
      inv_ff   <= inv_in;
   end

   assign rsp_strobe          = str_ff;
   assign rsp_remainder_bits  = rem_ff;
   assign rsp_modulus_invalid = inv_ff;

endmodule

`default_nettype wire

// File: hw/rtl/float_positive_modulo.sv
// ----------------------------------------------------------------------------
// float_positive_modulo
// Non-negative single-precision remainder built on IEEE add, compare, halve.
// ----------------------------------------------------------------------------
// A request beat (dividend, modulus) is taken when start is high and busy is
// low. The front classifies the modulus (huge, invalid, normal) and pushes the
// beat into a two-entry queue; busy is high only while that queue is full.
// The back pops one entry at a time and runs it on one shared 4-stage adder.
// Each result is shown for a single cycle with rsp_strobe high; the receiver
// cannot stall it and must take it then.
// A huge or invalid modulus is answered from the queue head without the adder.
// Otherwise a negative dividend is first lifted by alternate lift adds and lift
// doublings; then the modulus is doubled, and each halving step is followed by
// a subtraction when the dividend is not below it. Worst case, a dividend near
// -max over the smallest subnormal modulus: 278 lift adds, 277 lift doublings,
// then 128 doublings, halvings and subtractions. The adder is used one
// operation at a time. A new request can queue while an item is in progress.
// Reset empties the queue, idles the sequencer and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module float_positive_modulo #(
   parameter int DOUBLING_LIMIT = fpm_pkg::DOUBLING_LIMIT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_value_bits,
   input  wire logic [31:0] req_modulus_bits,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_remainder_bits,
   output logic             rsp_modulus_invalid
);

   fpm_pkg::entry_type        push_entry;
   fpm_pkg::queue_status_type status;
   logic                      push, pop, full;

   fpm_front u_front (
      .start            (start),
      .req_value_bits   (req_value_bits),
      .req_modulus_bits (req_modulus_bits),
      .queue_full       (full),
      .push_entry       (push_entry),
      .push             (push),
      .busy             (busy)
   );

   fpm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .status     (status),
      .full       (full)
   );

   fpm_back #(
      .DOUBLING_LIMIT (DOUBLING_LIMIT)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .status              (status),
      .pop                 (pop),
      .rsp_strobe          (rsp_strobe),
      .rsp_remainder_bits  (rsp_remainder_bits),
      .rsp_modulus_invalid (rsp_modulus_invalid)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

   a_strobe_known: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$isunknown({rsp_remainder_bits, rsp_modulus_invalid}))
      else $error("unknown result beat");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// float_positive_modulo testbench
// Drives (dividend, modulus) beats through the start/busy handshake and checks
// each result against a bit-level single-precision predictor or a set value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   localparam logic [31:0] QNAN      = 32'h7FC0_0000;
   localparam int          MAX_DOUBL = 128;
   localparam int          MAX_LIFT  = 400;
   localparam int          N_RANDOM  = 1030;

   typedef struct {
      logic [31:0] rem;
      logic        inv;
   } remainder_type;

   typedef struct {
      logic [31:0] v;
      logic [31:0] m;
      bit          typed;
      logic [31:0] rem;
      logic        inv;
   } vector_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_value_bits;
   logic [31:0] req_modulus_bits;
   logic        rsp_strobe;
   logic [31:0] rsp_remainder_bits;
   logic        rsp_modulus_invalid;

   remainder_type pending_rem[$];
   int            errors;
   bit            idle_on;

   float_positive_modulo dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_value_bits      (req_value_bits),
      .req_modulus_bits    (req_modulus_bits),
      .rsp_strobe          (rsp_strobe),
      .rsp_remainder_bits  (rsp_remainder_bits),
      .rsp_modulus_invalid (rsp_modulus_invalid)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("[float_positive_modulo] ERROR");
      $finish;
   end

   // ---- single-precision arithmetic, round to nearest even ----
   function automatic bit sp_nan(input logic [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] != 0;
   endfunction

   function automatic bit sp_below_zero(input logic [31:0] x);
      return x[31] && x[30:0] != 0 && !sp_nan(x);
   endfunction

   function automatic bit sp_above_zero(input logic [31:0] x);
      return !x[31] && x[30:0] != 0 && !sp_nan(x);
   endfunction

   function automatic bit sp_ge(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ka;
      logic [31:0] kb;
      if (sp_nan(a) || sp_nan(b)) return 1'b0;
      if (a[30:0] == 0) a = 32'd0;
      if (b[30:0] == 0) b = 32'd0;
      ka = a[31] ? ~a : (a | 32'h8000_0000);
      kb = b[31] ? ~b : (b | 32'h8000_0000);
      return ka >= kb;
   endfunction

   function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] x;
      logic [31:0] y;
      logic [27:0] sx;
      logic [27:0] sy;
      logic [27:0] ty;
      logic [27:0] s;
      logic [24:0] r;
      int          ex;
      int          ey;
      int          d;
      if (sp_nan(a) || sp_nan(b)) return QNAN;
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
         if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && a[31] != b[31]) return QNAN;
         return (a[30:23] == 8'hFF) ? a : b;
      end
      if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
      if (a[30:0] == 0) return b;
      if (b[30:0] == 0) return a;
      if (a[30:0] >= b[30:0]) begin
         x = a;
         y = b;
      end else begin
         x = b;
         y = a;
      end
      ex = (x[30:23] == 0) ? 1 : x[30:23];
      ey = (y[30:23] == 0) ? 1 : y[30:23];
      sx = {1'b0, x[30:23] != 0, x[22:0], 3'b000};
      ty = {1'b0, y[30:23] != 0, y[22:0], 3'b000};
      d = ex - ey;
      if (d > 27) begin
         sy = 28'd1;
      end else begin
         sy = ty >> d;
         if ((ty & ((28'd1 << d) - 28'd1)) != 0) sy[0] = 1'b1;
      end
      if (x[31] == y[31]) begin
         s = sx + sy;
         if (s[27]) begin
            s = (s >> 1) | {27'd0, s[0]};
            ex++;
         end
      end else begin
         s = sx - sy;
         if (s == 0) return 32'd0;
      end
      while (!s[26] && ex > 1) begin
         s = s << 1;
         ex--;
      end
      r = {1'b0, s[26:3]} + {24'd0, s[2] & ((|s[1:0]) | s[3])};
      if (r[24]) begin
         r = r >> 1;
         ex++;
      end
      if (ex >= 255) return {x[31], 8'hFF, 23'd0};
      return {x[31], r[23] ? ex[7:0] : 8'd0, r[22:0]};
   endfunction

   function automatic logic [31:0] sp_halve(input logic [31:0] x);
      logic [23:0] sig;
      logic [23:0] q;
      if (x[30:23] == 8'hFF) return x;
      if (x[30:23] > 8'd1) return {x[31], x[30:23] - 8'd1, x[22:0]};
      sig = {x[30:23] == 8'd1, x[22:0]};
      q = (sig >> 1) + {23'd0, sig[0] & sig[1]};
      return {x[31], 7'd0, q};
   endfunction

   function automatic remainder_type positive_remainder(input logic [31:0] vin,
                                                        input logic [31:0] m);
      remainder_type res;
      logic [31:0]   v;
      logic [31:0]   t;
      int            n;
      int            g;
      v = vin;
      t = m;
      n = 0;
      res.inv = 1'b0;
      if ((m[30:23] == 8'hFF && m[22:0] == 0) || (m[30:23] != 8'hFF &&
          (m[30:23] > 8'd180 || (m[30:23] == 8'd180 && m[22:0] != 0)))) begin
         res.rem = 32'd0;
         return res;
      end
      if (!sp_above_zero(m)) begin
         res.inv = 1'b1;
         res.rem = vin;
         return res;
      end
      if (sp_below_zero(v)) begin
         g = 0;
         while (sp_below_zero(sp_add(v, t)) && g < MAX_LIFT) begin
            t = sp_add(t, t);
            g++;
         end
         v = sp_add(v, t);
         t = m;
      end
      if (sp_above_zero(v)) begin
         while (sp_ge(v, t) && n < MAX_DOUBL) begin
            t = sp_add(t, t);
            n++;
         end
         while (n > 0) begin
            n--;
            t = sp_halve(t);
            if (sp_ge(v, t)) v = sp_add(v, {~t[31], t[30:0]});
         end
      end
      res.rem = (sp_nan(v) && !sp_nan(vin)) ? QNAN : v;
      return res;
   endfunction

   // ---- drive one beat; expectation queued at the accepting edge ----
   task automatic send_beat(input vector_type vec);
      remainder_type want;
      want = vec.typed ? remainder_type'{rem: vec.rem, inv: vec.inv}
                       : positive_remainder(vec.v, vec.m);
      @(negedge clock);
      start            <= 1'b1;
      req_value_bits   <= vec.v;
      req_modulus_bits <= vec.m;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rem.push_back(want);
      if (idle_on && $urandom_range(0, 99) < 31) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   endtask

   task automatic drain_pending;
      @(negedge clock);
      start <= 1'b0;
      while (pending_rem.size() != 0) @(posedge clock);
   endtask

   function automatic vector_type random_vector;
      vector_type  vec;
      int          kind;
      int          me;
      int          ve;
      kind = $urandom_range(0, 99);
      vec.typed = 1'b0;
      vec.rem = 32'd0;
      vec.inv = 1'b0;
      if (kind < 10) begin
         vec.v = $urandom;
         vec.m = $urandom;
      end else if (kind < 18) begin
         vec.v = $urandom;
         case ($urandom_range(0, 4))
            0: vec.m = {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
            1: vec.m = {1'b1, 31'($urandom)};
            2: vec.m = {$urandom_range(0, 1) == 1, 31'd0};
            3: vec.m = {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 8388607))};
            default: vec.m = {1'b0, 8'($urandom_range(179, 254)), 23'($urandom)};
         endcase
      end else begin
         me = $urandom_range(0, 200);
         ve = me + $urandom_range(0, 22);
         if (ve > 254) ve = 254;
         vec.m = {1'b0, 8'(me), 23'($urandom)};
         vec.v = {$urandom_range(0, 99) < 20, 8'(ve), 23'($urandom)};
         if (vec.m[30:0] == 0) vec.m[0] = 1'b1;
      end
      return vec;
   endfunction

   // ---- result check ----
   always @(posedge clock) begin
      remainder_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rem.size() == 0) begin
            $error("unexpected result beat: remainder_bits %h", rsp_remainder_bits);
            errors++;
         end else begin
            want = pending_rem.pop_front();
            if (rsp_remainder_bits !== want.rem) begin
               $error("remainder_bits: expected %h, actual %h", want.rem, rsp_remainder_bits);
               errors++;
            end
            if (rsp_modulus_invalid !== want.inv) begin
               $error("modulus_invalid: expected %b, actual %b", want.inv,
                      rsp_modulus_invalid);
               errors++;
            end
         end
      end
   end

   vector_type directed[] = '{
      '{32'h4000_0000, 32'h7F80_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{32'hC2F6_0000, 32'hFF80_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{32'h7F7F_FFFF, 32'h5A80_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{32'h3F80_0000, 32'h5A00_0001, 1'b1, 32'h0000_0000, 1'b0},
      '{32'h3F80_0000, 32'hDA80_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{32'h40E0_0000, 32'h0000_0000, 1'b1, 32'h40E0_0000, 1'b1},
      '{32'hC0E0_0000, 32'h8000_0000, 1'b1, 32'hC0E0_0000, 1'b1},
      '{32'hFFFF_FFFF, 32'hBF80_0000, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{32'h0000_0001, 32'h7FC0_0000, 1'b1, 32'h0000_0001, 1'b1},
      '{32'h3F80_0000, 32'hFFFF_FFFF, 1'b1, 32'h3F80_0000, 1'b1},
      '{32'h0000_0000, 32'h3F80_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{32'h8000_0000, 32'h3F80_0000, 1'b1, 32'h8000_0000, 1'b0},
      '{32'h7FC0_0001, 32'h3F80_0000, 1'b1, 32'h7FC0_0001, 1'b0},
      '{32'h7F80_0000, 32'h3F80_0000, 1'b1, QNAN,          1'b0},
      '{32'hFF80_0000, 32'h3F80_0000, 1'b1, QNAN,          1'b0},
      '{32'h40E0_0000, 32'h4000_0000, 1'b0, 32'h0,         1'b0},
      '{32'hBFC0_0000, 32'h3F80_0000, 1'b0, 32'h0,         1'b0},
      '{32'h7F7F_FFFF, 32'h3F80_0000, 1'b0, 32'h0,         1'b0},
      '{32'hFF7F_FFFF, 32'h3F80_0000, 1'b0, 32'h0,         1'b0},
      '{32'h0000_0001, 32'h0000_0001, 1'b0, 32'h0,         1'b0},
      '{32'h3F80_0000, 32'h0000_0001, 1'b0, 32'h0,         1'b0},
      '{32'h5F00_0000, 32'h5A00_0000, 1'b0, 32'h0,         1'b0},
      '{32'h3F80_0000, 32'h7F7F_FFFF, 1'b0, 32'h0,         1'b0},
      '{32'hC47A_0000, 32'h3DCC_CCCD, 1'b0, 32'h0,         1'b0}
   };

   initial begin
      errors = 0;
      idle_on = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_value_bits = 32'd0;
      req_modulus_bits = 32'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_beat(directed[i]);
      drain_pending();

      for (int i = 0; i < N_RANDOM; i++) begin
         idle_on = !(i >= 300 && i < 500);
         if (i == 600) drain_pending();
         send_beat(random_vector());
      end
      drain_pending();
      repeat (100) @(posedge clock);

      if (errors == 0 && pending_rem.size() == 0) begin
         $display("[float_positive_modulo] OK");
      end else begin
         $display("[float_positive_modulo] ERROR");
      end
      $finish;
   end

endmodule
